// File: hdl/epoch_to_calendar_field_assert.svh
// assertion helpers shared by the calendar field block
`ifndef EPOCH_TO_CALENDAR_FIELD_ASSERT_SVH
`define EPOCH_TO_CALENDAR_FIELD_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ETCF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ETCF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/etcf_pkg.sv
package etcf_pkg;

  localparam int unsigned VALUE_W   = 14;
  localparam int unsigned PIPE_DEPTH = 13;

  // supported window, 0000-01-01 00:00:00 to 9999-12-31 23:59:59
  localparam logic signed [38:0] FIRST_SECOND = -39'sd62167219200;
  localparam logic signed [38:0] LAST_SECOND  = 39'sd253402300799;
  localparam logic [38:0] EPOCH_OFFSET = 39'd62167219200;

  // reciprocals, exact over the value range at each use
  localparam logic [31:0] DAY_MAGIC  = 32'd3257812231; // /675, shift 41
  localparam logic [22:0] ERA_MAGIC  = 23'd7525902;    // /146097, shift 40
  localparam logic [22:0] WEEK_MAGIC = 23'd4793491;    // /7, shift 25
  localparam logic [17:0] MIN_MAGIC  = 18'd139811;     // /60, shift 23
  localparam logic [11:0] HOUR_MAGIC = 12'd2185;       // /60, shift 17
  localparam logic [17:0] CYC_MAGIC  = 18'd183860;     // /1460 shift 28, /365 shift 26
  localparam logic [11:0] MON_MAGIC  = 12'd3427;       // /153, shift 19
  localparam logic [9:0]  SEV_MAGIC  = 10'd586;        // /7 for small values, shift 12

  localparam logic [21:0] MARCH_SHIFT = 22'd146037;    // one era less 60 days

  localparam logic [1:0] ADDR_FIELD_SELECT = 2'd0;

  typedef enum logic [3:0] {
    FS_YEAR     = 4'd0,
    FS_MONTH    = 4'd1,
    FS_DAY      = 4'd2,
    FS_HOUR     = 4'd3,
    FS_MINUTE   = 4'd4,
    FS_SECOND   = 4'd5,
    FS_QUARTER  = 4'd6,
    FS_ISO_WEEK = 4'd7,
    FS_DOY      = 4'd8,
    FS_DOW      = 4'd9,
    FS_ISODOW   = 4'd10
  } field_sel_e;

  // days before the first of a month, january is 1
  function automatic logic [8:0] month_start(input logic [3:0] mon);
    logic [8:0] r;
    case (mon)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // days before a month counted from march 1, march is 0
  function automatic logic [8:0] march_offset(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // leap rule on a year taken modulo 400, range 0..400
  function automatic logic leap_in_era(input logic [8:0] ry);
    return (ry[1:0] == 2'd0) && (ry != 9'd100) && (ry != 9'd200) && (ry != 9'd300);
  endfunction

endpackage

// File: hdl/epoch_to_calendar_field.sv
// calendar field extractor for unix timestamps
// input stream: tdata carries the signed seconds since 1970-01-01 00:00:00 utc,
// tuser marks the value absent; one transfer per timestamp
// output stream: tdata carries the chosen field, tuser flags a null result
// (absent input, instant outside years 0..9999 or a selector above 10), value 0
// the apb register at byte address 0 picks the field: year, month, day, hour,
// minute, second, quarter, iso week, day of year, weekday (sunday 0), iso weekday
// 13 register stages: the result is held in the last stage until the receiver is
// ready; a new timestamp is taken every cycle while the output is not stalled, and
// the depth is set by the chain of reciprocal multiplies that split seconds
// into days, eras, years and months
// when the receiver stalls the whole pipeline holds and s_axis_tready drops,
// nothing is lost or repeated
// reset empties the pipeline and sets the selector to year
// the user must write the selector only while no transfer is in flight; the block does not enforce it
`include "epoch_to_calendar_field_assert.svh"

module epoch_to_calendar_field
  import etcf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [38:0] epoch_seconds, [39] zero fill
  input  logic        s_axis_tuser,  // [0] value_absent
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [13:0] field_value, [15:14] zero fill
  output logic        m_axis_tuser   // [0] result_null
);

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  logic [3:0] field_select_q;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == ADDR_FIELD_SELECT[0]);
  assign prdata    = (paddr[2] == ADDR_FIELD_SELECT[0]) ? {28'd0, field_select_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_select_q <= FS_YEAR;
    end else if (cfg_write) begin
      field_select_q <= pwdata[3:0];
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control: every stage moves together, stalled only by the receiver
  // ---------------------------------------------------------------------------
  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld_q;

  assign adv           = !vld_q[PIPE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  // ---------------------------------------------------------------------------
  // datapath stage registers
  // ---------------------------------------------------------------------------
  // input register
  logic [38:0] ep1_q;
  logic        ab1_q;
  // offset seconds and range check
  logic [38:0] t2_q;
  logic        nul2_q;
  // day count
  logic [21:0] qd3_q;
  logic [9:0]  xl3_q;
  logic [6:0]  lo3_q;
  logic        nul3_q;
  // days, march-based day count, second of day
  logic [21:0] d4_q, z4_q;
  logic [16:0] sod4_q;
  logic        nul4_q;
  // era, weekday quotient, minute of day
  logic [4:0]  era5_q;
  logic [17:0] zl5_q;
  logic [2:0]  dl5_q, wq5_q;
  logic [10:0] mt5_q;
  logic [5:0]  sl5_q;
  logic        nul5_q;
  // day of era, weekday, hour
  logic [4:0]  era6_q;
  logic [17:0] doe6_q;
  logic [2:0]  wday6_q;
  logic [5:0]  sec6_q, mtl6_q;
  logic [4:0]  hr6_q;
  logic        nul6_q;
  // corrected day of era
  logic [4:0]  era7_q;
  logic [17:0] doe7_q, n7_q;
  logic [2:0]  wday7_q;
  logic [5:0]  sec7_q, min7_q;
  logic [4:0]  hr7_q;
  logic        nul7_q;
  // year of era
  logic [8:0]  yoe8_q;
  logic [4:0]  era8_q;
  logic [17:0] doe8_q;
  logic [2:0]  wday8_q;
  logic [5:0]  sec8_q, min8_q;
  logic [4:0]  hr8_q;
  logic        nul8_q;
  // day of march-based year
  logic [8:0]  dm9_q, yoe9_q;
  logic [4:0]  era9_q;
  logic [2:0]  wday9_q;
  logic [5:0]  sec9_q, min9_q;
  logic [4:0]  hr9_q;
  logic        nul9_q;
  // march-based month
  logic [3:0]  mp10_q;
  logic [8:0]  dm10_q, yoe10_q;
  logic [4:0]  era10_q;
  logic [2:0]  wday10_q;
  logic [5:0]  sec10_q, min10_q;
  logic [4:0]  hr10_q;
  logic        nul10_q;
  // calendar date
  logic [13:0] year11_q;
  logic [3:0]  mon11_q;
  logic [4:0]  mday11_q;
  logic [8:0]  yday11_q;
  logic [2:0]  qtr11_q, wday11_q, isow11_q;
  logic        lc11_q, lp11_q;
  logic [5:0]  sec11_q, min11_q;
  logic [4:0]  hr11_q;
  logic        nul11_q;
  // raw iso week and day of year less one, modulo 7
  logic [5:0]  wkr12_q;
  logic [2:0]  rem12_q;
  logic [13:0] year12_q;
  logic [3:0]  mon12_q;
  logic [4:0]  mday12_q;
  logic [8:0]  yday12_q;
  logic [2:0]  qtr12_q, wday12_q, isow12_q;
  logic        lc12_q, lp12_q;
  logic [5:0]  sec12_q, min12_q;
  logic [4:0]  hr12_q;
  logic        nul12_q;
  // result register
  logic [13:0] val_q;
  logic        nul_q;

  // ---------------------------------------------------------------------------
  // combinational work between stages
  // ---------------------------------------------------------------------------
  // stage 2: window check and shift to seconds since 0000-01-01
  logic [38:0] t2_d;
  logic        nul2_d;
  assign t2_d   = ep1_q + EPOCH_OFFSET;
  assign nul2_d = ab1_q || (signed'(ep1_q) < FIRST_SECOND) || (signed'(ep1_q) > LAST_SECOND);

  // stage 3: days = (t >> 7) / 675, since 86400 = 128 * 675
  logic [63:0] day_prod;
  assign day_prod = 64'(t2_q[38:7]) * 64'(DAY_MAGIC);

  // stage 4: remainder rebuilds the second of day
  logic [31:0] rem_prod;
  logic [9:0]  r4_d;
  assign rem_prod = 32'(qd3_q) * 32'd675;
  assign r4_d     = xl3_q - rem_prod[9:0];

  // stage 5: era, week quotient and minute of day
  logic [44:0] era_prod, wk_prod;
  logic [21:0] dd5;
  logic [34:0] mt_prod;
  assign era_prod = 45'(z4_q) * 45'(ERA_MAGIC);
  assign dd5      = d4_q + 22'd6;      // 0000-01-01 was a saturday
  assign wk_prod  = 45'(dd5) * 45'(WEEK_MAGIC);
  assign mt_prod  = 35'(sod4_q) * 35'(MIN_MAGIC);

  // stage 6: remainders, all known to fit their narrow widths
  logic [22:0] era_off;
  logic [2:0]  wq7;
  logic [16:0] sec_off;
  logic [22:0] hr_prod;
  assign era_off = 23'(era5_q) * 23'd146097;
  assign wq7     = wq5_q * 3'd7;
  assign sec_off = 17'(mt5_q) * 17'd60;
  assign hr_prod = 23'(mt5_q) * 23'(HOUR_MAGIC);

  // stage 7: doe - doe/1460 + doe/36524 - doe/146096
  logic [35:0] cyc_prod;
  logic [2:0]  b7;
  logic        c7;
  logic [10:0] min_off;
  assign cyc_prod = 36'(doe6_q) * 36'(CYC_MAGIC);
  assign b7 = 3'(doe6_q >= 18'd36524) + 3'(doe6_q >= 18'd73048)
            + 3'(doe6_q >= 18'd109572) + 3'(doe6_q >= 18'd146096);
  assign c7      = (doe6_q == 18'd146096);
  assign min_off = 11'(hr6_q) * 11'd60;

  // stage 8: year of era
  logic [35:0] yoe_prod;
  assign yoe_prod = 36'(n7_q) * 36'(CYC_MAGIC);

  // stage 9: day within the march-based year
  logic [1:0]  y100;
  logic [17:0] base9, dm_full;
  assign y100    = 2'(yoe8_q >= 9'd100) + 2'(yoe8_q >= 9'd200) + 2'(yoe8_q >= 9'd300);
  assign base9   = 18'(yoe8_q) * 18'd365 + 18'(yoe8_q[8:2]) - 18'(y100);
  assign dm_full = doe8_q - base9;

  // stage 10: march-based month
  logic [10:0] num10;
  logic [22:0] mp_prod;
  assign num10   = 11'(dm9_q) * 11'd5 + 11'd2;
  assign mp_prod = 23'(num10) * 23'(MON_MAGIC);

  // stage 11: calendar date
  logic [8:0] mday_full, ry11, rp11, yday_d;
  logic [3:0] mon_d;
  logic [4:0] mday_d;
  logic       carry11, lc_d;
  logic [2:0] qtr_d, isow_d;
  logic [13:0] year_d;
  assign mday_full = dm10_q - march_offset(mp10_q) + 9'd1;
  assign mday_d    = mday_full[4:0];
  assign carry11   = (mp10_q >= 4'd10);            // january and february
  assign mon_d     = carry11 ? (mp10_q - 4'd9) : (mp10_q + 4'd3);
  assign ry11      = yoe10_q + 9'(carry11);
  assign rp11      = ry11 - 9'd1;                  // zero wraps to a non-leap code
  assign lc_d      = leap_in_era(ry11);
  assign year_d    = 14'(ry11) + 14'(era10_q) * 14'd400 - 14'd400;
  assign yday_d    = month_start(mon_d) + 9'(mday_d) + 9'((mon_d > 4'd2) && lc_d);
  assign qtr_d     = (mon_d <= 4'd3) ? 3'd1 : (mon_d <= 4'd6) ? 3'd2 :
                     (mon_d <= 4'd9) ? 3'd3 : 3'd4;
  assign isow_d    = (wday10_q == 3'd0) ? 3'd7 : wday10_q;

  // stage 12: raw iso week and weekday of january 1 helper
  logic [8:0]  s12, y1_12;
  logic [18:0] wkr_prod, q_prod;
  logic [5:0]  q12;
  logic [2:0]  q7_12;
  assign s12      = yday11_q + 9'd10 - 9'(isow11_q);
  assign wkr_prod = 19'(s12) * 19'(SEV_MAGIC);
  assign y1_12    = yday11_q - 9'd1;
  assign q_prod   = 19'(y1_12) * 19'(SEV_MAGIC);
  assign q12      = q_prod[17:12];
  assign q7_12    = q12[2:0] * 3'd7;

  // stage 13: iso week at year edges and field selection
  logic [3:0]  jsum;
  logic [2:0]  jan1;
  logic        cur53, prev53;
  logic [5:0]  wk_last, wk_final;
  logic [13:0] val_d;
  logic        nul_d;
  assign jsum    = 4'(wday12_q) + 4'd7 - 4'(rem12_q);
  assign jan1    = (jsum >= 4'd7) ? 3'(jsum - 4'd7) : jsum[2:0];
  // 53 weeks when january 1 is a thursday, or a wednesday in a leap year
  assign cur53   = (jan1 == 3'd4) || (lc12_q && (jan1 == 3'd3));
  // previous year, seen from the weekday of this january 1
  assign prev53  = (jan1 == 3'd5) || (lp12_q && (jan1 == 3'd6));
  assign wk_last = cur53 ? 6'd53 : 6'd52;
  assign wk_final = (wkr12_q == 6'd0) ? (prev53 ? 6'd53 : 6'd52) :
                    (wkr12_q > wk_last) ? 6'd1 : wkr12_q;

  always_comb begin
    val_d = '0;
    nul_d = nul12_q;
    case (field_select_q)
      FS_YEAR:     val_d = year12_q;
      FS_MONTH:    val_d = 14'(mon12_q);
      FS_DAY:      val_d = 14'(mday12_q);
      FS_HOUR:     val_d = 14'(hr12_q);
      FS_MINUTE:   val_d = 14'(min12_q);
      FS_SECOND:   val_d = 14'(sec12_q);
      FS_QUARTER:  val_d = 14'(qtr12_q);
      FS_ISO_WEEK: val_d = 14'(wk_final);
      FS_DOY:      val_d = 14'(yday12_q);
      FS_DOW:      val_d = 14'(wday12_q);
      FS_ISODOW:   val_d = 14'(isow12_q);
      default:     nul_d = 1'b1;           // selector without meaning
    endcase
    if (nul_d) begin
      val_d = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers, no reset needed
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ep1_q  <= s_axis_tdata[38:0];
      ab1_q  <= s_axis_tuser;

      t2_q   <= t2_d;
      nul2_q <= nul2_d;

      qd3_q  <= day_prod[62:41];
      xl3_q  <= t2_q[16:7];
      lo3_q  <= t2_q[6:0];
      nul3_q <= nul2_q;

      d4_q   <= qd3_q;
      z4_q   <= qd3_q + MARCH_SHIFT;
      sod4_q <= {r4_d, lo3_q};
      nul4_q <= nul3_q;

      era5_q <= era_prod[44:40];
      zl5_q  <= z4_q[17:0];
      dl5_q  <= dd5[2:0];
      wq5_q  <= wk_prod[27:25];
      mt5_q  <= mt_prod[33:23];
      sl5_q  <= sod4_q[5:0];
      nul5_q <= nul4_q;

      era6_q  <= era5_q;
      doe6_q  <= zl5_q - era_off[17:0];
      wday6_q <= dl5_q - wq7;
      sec6_q  <= sl5_q - sec_off[5:0];
      hr6_q   <= hr_prod[21:17];
      mtl6_q  <= mt5_q[5:0];
      nul6_q  <= nul5_q;

      era7_q  <= era6_q;
      doe7_q  <= doe6_q;
      n7_q    <= doe6_q - 18'(cyc_prod[34:28]) + 18'(b7) - 18'(c7);
      wday7_q <= wday6_q;
      sec7_q  <= sec6_q;
      min7_q  <= mtl6_q - min_off[5:0];
      hr7_q   <= hr6_q;
      nul7_q  <= nul6_q;

      yoe8_q  <= yoe_prod[34:26];
      era8_q  <= era7_q;
      doe8_q  <= doe7_q;
      wday8_q <= wday7_q;
      sec8_q  <= sec7_q;
      min8_q  <= min7_q;
      hr8_q   <= hr7_q;
      nul8_q  <= nul7_q;

      dm9_q   <= dm_full[8:0];
      yoe9_q  <= yoe8_q;
      era9_q  <= era8_q;
      wday9_q <= wday8_q;
      sec9_q  <= sec8_q;
      min9_q  <= min8_q;
      hr9_q   <= hr8_q;
      nul9_q  <= nul8_q;

      mp10_q   <= mp_prod[22:19];
      dm10_q   <= dm9_q;
      yoe10_q  <= yoe9_q;
      era10_q  <= era9_q;
      wday10_q <= wday9_q;
      sec10_q  <= sec9_q;
      min10_q  <= min9_q;
      hr10_q   <= hr9_q;
      nul10_q  <= nul9_q;

      year11_q <= year_d;
      mon11_q  <= mon_d;
      mday11_q <= mday_d;
      yday11_q <= yday_d;
      qtr11_q  <= qtr_d;
      lc11_q   <= lc_d;
      lp11_q   <= leap_in_era(rp11);
      wday11_q <= wday10_q;
      isow11_q <= isow_d;
      sec11_q  <= sec10_q;
      min11_q  <= min10_q;
      hr11_q   <= hr10_q;
      nul11_q  <= nul10_q;

      wkr12_q  <= wkr_prod[17:12];
      rem12_q  <= y1_12[2:0] - q7_12;
      year12_q <= year11_q;
      mon12_q  <= mon11_q;
      mday12_q <= mday11_q;
      yday12_q <= yday11_q;
      qtr12_q  <= qtr11_q;
      lc12_q   <= lc11_q;
      lp12_q   <= lp11_q;
      wday12_q <= wday11_q;
      isow12_q <= isow11_q;
      sec12_q  <= sec11_q;
      min12_q  <= min11_q;
      hr12_q   <= hr11_q;
      nul12_q  <= nul11_q;

      val_q <= val_d;
      nul_q <= nul_d;
    end
  end

  assign m_axis_tdata = {2'b00, val_q};
  assign m_axis_tuser = nul_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `ETCF_ASSERT_IMP(a_null_zero, m_axis_tvalid && m_axis_tuser,
                   m_axis_tdata == 16'd0, "null result carries a nonzero value")
  `ETCF_ASSERT_IMP(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready,
                   !s_axis_tready, "input taken while the result is stalled")
  `ETCF_ASSERT_IMP(a_month_range,
                   m_axis_tvalid && !m_axis_tuser && (field_select_q == FS_MONTH),
                   (val_q >= 14'd1) && (val_q <= 14'd12), "month out of range")
  `ETCF_ASSERT_IMP(a_week_range,
                   m_axis_tvalid && !m_axis_tuser && (field_select_q == FS_ISO_WEEK),
                   (val_q >= 14'd1) && (val_q <= 14'd53), "iso week out of range")
  `ETCF_ASSERT_NXT(a_cfg_write, cfg_write,
                   field_select_q == $past(pwdata[3:0]), "selector write lost")

endmodule
